// ===== rtl/modular_arithmetic_unit_assert.svh =====
// Assertion macros for the modular arithmetic unit.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MAU_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MAU_ASSERT(label, clk, rst_n, prop, msg)
`define MAU_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/mau_pkg.sv =====
package mau_pkg;
  localparam int unsigned OpW  = 3;
  localparam int unsigned StW  = 2;
  localparam int unsigned ExpW = 64;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_INV = 3'd4, OP_POW = 3'd5, OP_NEG = 3'd6, OP_NOP = 3'd7
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK = 2'd0, ST_ZERO = 2'd1, ST_NOT_COPRIME = 2'd2, ST_RSVD = 2'd3
  } status_e;
endpackage

// ===== rtl/mau_if.sv =====
interface mau_in_if #(parameter int unsigned W = 31) ();
  logic         valid;
  logic         ready;
  logic [2:0]   operation;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;
  logic [63:0]  exponent;
  modport source (output valid, operation, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_out_if #(parameter int unsigned W = 31) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] residue;
  logic [1:0]   status;
  modport source (output valid, residue, status, input ready);
  modport sink   (input valid, residue, status, output ready);
endinterface

// ===== rtl/mau_serial.sv =====
// Bit-serial helper, one bit per cycle.
// Reduce: x mod m with quotient (restoring division, MSB first).
// Multiply: x*y mod m, x already below m, multiplier y scanned MSB first.
// done_o is high in the last busy cycle, when r_o and q_o carry the final
// values; a new start may be given in that same cycle.
module mau_serial #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         mul_i,      // 1: x*y mod m, 0: x mod m
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] r_o,
  output logic [W-1:0] q_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, mul_q, mul_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d, r_q, r_d, q_q, q_d, m_q, m_d;
  logic [W:0]    dbl, red, sum1, t;
  logic [W-1:0]  step_r, step_q;

  // one step: doubled remainder plus next dividend bit (reduce) or doubled
  // accumulator plus x when the multiplier bit is set (mul)
  always_comb begin
    dbl  = {r_q, (mul_q ? 1'b0 : x_q[W-1])};
    red  = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum1 = red + {1'b0, x_q};
    t    = (mul_q && y_q[W-1]) ? sum1 : red;
    if (t >= {1'b0, m_q}) t = t - {1'b0, m_q};
    step_r = t[W-1:0];
    step_q = {q_q[W-2:0], (dbl >= {1'b0, m_q})};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mul_d  = mul_q;
    x_d = x_q; y_d = y_q; r_d = r_q; q_d = q_q; m_d = m_q;
    if (busy_q) begin
      r_d = step_r;
      q_d = step_q;
      if (mul_q) begin
        y_d = y_q << 1;
      end else begin
        x_d = x_q << 1;
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      mul_d  = mul_i;
      x_d = x_i; y_d = y_i; m_d = m_i; r_d = '0; q_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mul_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      mul_q  <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; r_q <= r_d; q_q <= q_d; m_q <= m_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign r_o    = step_r;
  assign q_o    = step_q;
endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// Add, sub and neg need only the operand reduction; mul needs a multiply, power a
// squaring per exponent bit up to the top set bit and a multiply per set bit, inverse
// a divide and a multiply per Euclid step, divide one more multiply; a zero divisor
// skips Euclid, a modulus below 2 skips all. One shared bit-serial unit, one item in
// flight; the next input is taken once the result is in the output register. Reset
// (async, active low) empties the block and loads modulus 998244353.
`include "modular_arithmetic_unit_assert.svh"
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int unsigned RESIDUE_WIDTH = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RESIDUE_WIDTH-1:0] cfg_wdata_i,
  mau_in_if.sink                   in_if,
  mau_out_if.source                out_if
);
  localparam int unsigned W = RESIDUE_WIDTH;
  localparam logic [W-1:0] ModReset = W'(64'd998244353);

  typedef enum logic [11:0] {
    S_IDLE  = 12'd1,   S_REDA  = 12'd2,   S_REDB = 12'd4,    S_DISP = 12'd8,
    S_MUL   = 12'd16,  S_PSTEP = 12'd32,  S_PMUL = 12'd64,   S_PSQ  = 12'd128,
    S_ESTEP = 12'd256, S_EDIV  = 12'd512, S_EMUL = 12'd1024, S_OUT  = 12'd2048
  } state_e;

  state_e state_q, state_d;
  logic [W-1:0] mod_q;
  logic [W-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [W-1:0] ea_q, ea_d, eb_q, eb_d, ex_q, ex_d, ey_q, ey_d;
  logic [63:0]  e_q, e_d;
  op_e          op_q, op_d;
  status_e      st_q, st_d;
  logic         ovld_q, ovld_d;
  logic [W-1:0] ores_q, ores_d;
  status_e      ost_q, ost_d;

  logic         s_start, s_mul, s_done;
  logic [W-1:0] s_x, s_y, s_m, s_r, s_q;
  logic         mod_ok;
  logic [W:0]   sum_w;
  logic [W-1:0] inv_v;

  mau_serial #(.W(W)) u_serial (
    .clk_i, .rst_ni, .start_i(s_start), .mul_i(s_mul), .x_i(s_x), .y_i(s_y),
    .m_i(s_m), .done_o(s_done), .r_o(s_r), .q_o(s_q)
  );

  assign mod_ok = (mod_q >= W'(2));
  assign in_if.ready    = (state_q == S_IDLE);
  assign out_if.valid   = ovld_q;
  assign out_if.residue = ores_q;
  assign out_if.status  = ost_q;

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; r_d = r_q; e_d = e_q; op_d = op_q; st_d = st_q;
    ea_d = ea_q; eb_d = eb_q; ex_d = ex_q; ey_d = ey_q;
    ovld_d = ovld_q && !out_if.ready;
    ores_d = ores_q; ost_d = ost_q;
    s_start = 1'b0; s_mul = 1'b0; s_x = a_q; s_y = a_q; s_m = mod_q;
    sum_w = {1'b0, a_q} + {1'b0, b_q};
    inv_v = (op_q == OP_INV) ? a_q : b_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          op_d = op_e'(in_if.operation);
          a_d  = in_if.operand_a;
          b_d  = in_if.operand_b;
          e_d  = in_if.exponent;
          st_d = ST_OK;
          r_d  = '0;
          if (mod_ok) begin
            s_start = 1'b1; s_x = in_if.operand_a;
            state_d = S_REDA;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_REDA: if (s_done) begin
        a_d = s_r; s_start = 1'b1; s_x = b_q; state_d = S_REDB;
      end
      S_REDB: if (s_done) begin
        b_d = s_r; state_d = S_DISP;
      end
      S_DISP: begin
        state_d = S_OUT;
        unique case (op_q)
          OP_ADD: begin
            if (sum_w >= {1'b0, mod_q}) r_d = W'(sum_w - {1'b0, mod_q});
            else r_d = sum_w[W-1:0];
          end
          OP_SUB: r_d = (a_q >= b_q) ? a_q - b_q : a_q + (mod_q - b_q);
          OP_NEG: r_d = (a_q == '0) ? '0 : mod_q - a_q;
          OP_MUL: begin
            s_start = 1'b1; s_mul = 1'b1; s_x = a_q; s_y = b_q; state_d = S_MUL;
          end
          OP_POW: begin
            r_d = W'(1); state_d = S_PSTEP;
          end
          OP_INV, OP_DIV: begin
            ea_d = inv_v; eb_d = mod_q; ex_d = W'(1); ey_d = '0;
            if (inv_v == '0) st_d = ST_ZERO;
            else state_d = S_ESTEP;
          end
          OP_NOP: r_d = '0;
          default: r_d = '0;
        endcase
      end
      S_MUL: if (s_done) begin
        r_d = s_r; state_d = S_OUT;
      end
      // one exponent bit per round, low bit first: res *= base, then square base
      S_PSTEP: begin
        if (e_q == '0) begin
          state_d = S_OUT;
        end else begin
          s_start = 1'b1; s_mul = 1'b1;
          if (e_q[0]) begin
            s_x = r_q; s_y = a_q; state_d = S_PMUL;
          end else begin
            s_x = a_q; s_y = a_q; state_d = S_PSQ;
          end
        end
      end
      S_PMUL: if (s_done) begin
        r_d = s_r;
        s_start = 1'b1; s_mul = 1'b1; s_x = a_q; s_y = a_q; state_d = S_PSQ;
      end
      S_PSQ: if (s_done) begin
        a_d = s_r; e_d = e_q >> 1; state_d = S_PSTEP;
      end
      S_ESTEP: begin
        if (eb_q != '0) begin
          // divide ea by eb: the unit takes eb as its modulus
          s_start = 1'b1; s_x = ea_q; s_m = eb_q; state_d = S_EDIV;
        end else if (ea_q != W'(1)) begin
          st_d = ST_NOT_COPRIME; state_d = S_OUT;
        end else if (op_q == OP_INV) begin
          r_d = ex_q; state_d = S_OUT;
        end else begin
          s_start = 1'b1; s_mul = 1'b1; s_x = a_q; s_y = ex_q; state_d = S_MUL;
        end
      end
      // quotient times ey mod modulus; the quotient is used as the multiplier
      S_EDIV: if (s_done) begin
        ea_d = eb_q; eb_d = s_r;
        s_start = 1'b1; s_mul = 1'b1; s_x = ey_q; s_y = s_q; state_d = S_EMUL;
      end
      S_EMUL: if (s_done) begin
        ex_d = ey_q;
        ey_d = (ex_q >= s_r) ? ex_q - s_r : ex_q + (mod_q - s_r);
        state_d = S_ESTEP;
      end
      S_OUT: begin
        if (!ovld_q || out_if.ready) begin
          ovld_d = 1'b1; ores_d = r_q; ost_d = st_q; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mod_q   <= ModReset;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; r_q <= r_d; e_q <= e_d; op_q <= op_d; st_q <= st_d;
    ea_q <= ea_d; eb_q <= eb_d; ex_q <= ex_d; ey_q <= ey_d;
    ores_q <= ores_d; ost_q <= ost_d;
  end

  `MAU_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `MAU_ASSERT(a_busy_no_ready, clk_i, rst_ni, (state_q != S_IDLE) |-> !in_if.ready, "ready")
  `MAU_ASSERT(a_status_ok, clk_i, rst_ni, ovld_q |-> (ost_q != ST_RSVD), "bad status")
  `MAU_ASSERT(a_res_range, clk_i, rst_ni, (ovld_q && mod_ok) |-> (ores_q < mod_q), "range")
  `MAU_ASSERT(a_out_hold, clk_i, rst_ni, (ovld_q && !out_if.ready) |=> ovld_q, "result dropped")
endmodule

// ===== bench/mau_checker.sv =====
`timescale 1ns / 100ps

module mau_checker import mau_pkg::*; #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [W-1:0] cfg_wdata_i,
  mau_in_if            in_ch,
  mau_out_if           out_ch,
  output int           errors_o,
  output int           pending_o,
  output int           results_o
);

  typedef struct packed {
    logic [W-1:0] residue;
    status_e      status;
  } mau_result_t;

  localparam logic [W-1:0] MODULUS_RESET = W'(998244353);

  logic [W-1:0] modulus_q;
  mau_result_t  expected_q[$];

  function automatic status_e mod_inverse(input longint v, input longint m,
                                          output longint inv);
    longint r0, r1, t0, t1, q, tmp;
    r0 = m;
    r1 = v;
    t0 = 0;
    t1 = 1;
    inv = 0;
    if (v == 0) return ST_ZERO;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return ST_NOT_COPRIME;
    inv = ((t0 % m) + m) % m;
    return ST_OK;
  endfunction

  function automatic mau_result_t predict_result(input logic [2:0] op_bits,
                                                 input logic [W-1:0] opa,
                                                 input logic [W-1:0] opb,
                                                 input logic [63:0] expo,
                                                 input logic [W-1:0] modv);
    mau_result_t r;
    longint m, a, b, acc, base, inv;
    op_e op;
    op = op_e'(op_bits);
    r.residue = '0;
    r.status = ST_OK;
    m = longint'(modv);
    if (m < 2) return r;
    a = longint'(opa) % m;
    b = longint'(opb) % m;
    acc = 0;
    case (op)
      OP_ADD: acc = (a + b) % m;
      OP_SUB: acc = (a - b + m) % m;
      OP_MUL: acc = (a * b) % m;
      OP_DIV: begin
        r.status = mod_inverse(b, m, inv);
        acc = (r.status == ST_OK) ? (a * inv) % m : 0;
      end
      OP_INV: begin
        r.status = mod_inverse(a, m, inv);
        acc = inv;
      end
      OP_POW: begin
        acc = 1 % m;
        if (expo == 0) acc = 1;
        base = a;
        for (int i = 0; i < 64; i++) begin
          if (expo[i]) acc = (acc * base) % m;
          base = (base * base) % m;
        end
      end
      OP_NEG: acc = (a == 0) ? 0 : m - a;
      default: acc = 0;
    endcase
    r.residue = W'(acc);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    results_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mau_result_t want;
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we_i) modulus_q <= cfg_wdata_i;
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_result(in_ch.operation, in_ch.operand_a,
                                            in_ch.operand_b, in_ch.exponent, modulus_q));
      if (out_ch.valid && out_ch.ready) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result transaction", longint'(out_ch.residue), 0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.residue !== want.residue)
            report_mismatch("residue", longint'(out_ch.residue), longint'(want.residue));
          if (out_ch.status !== want.status)
            report_mismatch("status", longint'(out_ch.status), longint'(want.status));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== bench/modular_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps

module modular_arithmetic_unit_tb import mau_pkg::*;;

  localparam int unsigned W = 31;
  localparam int STALL_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [W-1:0] cfg_wdata_i = '0;
  logic [W-1:0] cur_modulus = W'(998244353);
  logic         gaps_on = 1'b1;
  logic         in_taken = 1'b0;
  logic         out_taken = 1'b0;
  int           errors, pending, results;
  int           items_sent = 0;
  int           idle_cycles = 0;

  mau_in_if  #(.W(W)) in_ch ();
  mau_out_if #(.W(W)) out_ch ();

  modular_arithmetic_unit #(.RESIDUE_WIDTH(W)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  mau_checker #(.W(W)) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    in_ch.exponent = '0;
    out_ch.ready = 1'b0;
  end

  // Handshake flags sampled at the edge, read by the drivers at the falling edge.
  always @(posedge clk_i) begin
    in_taken <= in_ch.valid && in_ch.ready;
    out_taken <= out_ch.valid && out_ch.ready;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (in_taken || out_taken || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("modular_arithmetic_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input op_e op, input logic [W-1:0] a, input logic [W-1:0] b,
                           input logic [63:0] e);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    in_ch.exponent <= e;
    do @(negedge clk_i); while (!in_taken);
    items_sent++;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_modulus(input logic [W-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    cur_modulus = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] m1;
    m1 = (cur_modulus > 0) ? cur_modulus - 1 : '0;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return m1;
      2: return cur_modulus;
      3: return W'($urandom_range(0, 20));
      4: return '1;
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_exponent();
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return '0;
      2: return 64'(W'($urandom));
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic random_items(input int count, input bit pause_midway);
    op_e op;
    for (int i = 0; i < count; i++) begin
      op = op_e'($urandom_range(0, 7));
      if (op == OP_NOP && $urandom_range(0, 3) != 0) op = OP_MUL;
      if (pause_midway && i == count / 2) drain();
      send_item(op, pick_operand(), pick_operand(), pick_exponent());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, each operation, zero and non-invertible cases
    send_item(OP_ADD, '1, '1, '0);
    send_item(OP_ADD, W'(998244352), W'(1), '0);
    send_item(OP_SUB, '0, W'(1), '1);
    send_item(OP_SUB, '1, '0, '0);
    send_item(OP_MUL, W'(998244352), W'(998244352), '0);
    send_item(OP_MUL, '1, '1, '1);
    send_item(OP_DIV, W'(5), '0, '0);
    send_item(OP_DIV, W'(5), W'(998244353), '0);
    send_item(OP_DIV, W'(12345), W'(3), '0);
    send_item(OP_INV, '0, '1, '1);
    send_item(OP_INV, W'(998244353 * 2), '0, '0);
    send_item(OP_INV, W'(2), '0, '0);
    send_item(OP_INV, '1, '0, '0);
    send_item(OP_POW, '0, '1, '0);
    send_item(OP_POW, W'(3), '0, '0);
    send_item(OP_POW, W'(3), '0, '1);
    send_item(OP_POW, '1, '0, {32'h0, 32'hffffffff});
    send_item(OP_NEG, '0, '1, '1);
    send_item(OP_NEG, W'(998244353), '0, '0);
    send_item(OP_NEG, W'(1), '0, '0);
    send_item(OP_NOP, '1, '1, '1);

    // composite modulus gives the not-coprime path; moduli 1 and 0 give the below-2 path
    set_modulus(W'(1000000));
    send_item(OP_INV, W'(250), '0, '0);
    send_item(OP_DIV, W'(7), W'(40), '0);
    set_modulus(W'(1));
    send_item(OP_ADD, W'(3), W'(4), '0);
    send_item(OP_POW, W'(3), '0, '0);
    set_modulus('0);
    send_item(OP_INV, W'(3), '0, '0);

    set_modulus(W'(998244353));
    random_items(200, 1'b0);
    gaps_on <= 1'b0;
    random_items(150, 1'b0);
    gaps_on <= 1'b1;
    set_modulus('1);
    random_items(300, 1'b1);
    set_modulus(W'(2));
    random_items(120, 1'b0);
    set_modulus(W'($urandom_range(1000, 32'h7fffffff)));
    random_items(300, 1'b0);
    set_modulus(W'($urandom_range(3, 60)));
    random_items(250, 1'b0);
    set_modulus(W'(1000000));
    random_items(100, 1'b0);

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d items, %0d results over moduli 0, 1, 2, small, composite,",
             items_sent, results);
    $display("default and 2^31-1, with random gaps, a gap-free stretch and a full drain");
    if (errors == 0 && pending == 0) begin
      $display("modular_arithmetic_unit_tb OK");
    end else begin
      $display("modular_arithmetic_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
